[design/csg_pkg.sv]
// Shared types, constants and lookup tables for the console sound generator.
// No dependencies; used by console_sound_generator_top.
package csg_pkg;

    // Field widths
    localparam int PHASE_W = 21;
    localparam int LEVEL_W = 17;
    localparam int ADDR_W  = 16;
    localparam int OFF_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam int MIX_FRACTION_BITS_DEF = 16;

    // Mixer curve coefficients
    localparam longint unsigned PULSE_COEF = 64'd9552;
    localparam longint unsigned PULSE_BASE = 64'd8128;
    localparam longint unsigned TND_COEF   = 64'd16367;
    localparam longint unsigned TND_BASE   = 64'd24329;
    localparam int PULSE_N = 31;
    localparam int TND_N   = 203;

    // Reset values of the configuration registers
    localparam logic [PHASE_W-1:0] SAMPLE_STEP_RST = 21'd44100;
    localparam logic [PHASE_W-1:0] FRAME_STEP_RST  = 21'd240;
    localparam logic [PHASE_W-1:0] MODULUS_RST     = 21'd1789773;

    localparam logic [10:0] PERIOD_LIMIT    = 11'h7FF;
    localparam logic [15:0] DMC_WRAP_ADDR   = 16'h8000;
    localparam logic [6:0]  DMC_LEVEL_TOP   = 7'd125;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd2;

    // Register offsets from the sound base address
    localparam logic [OFF_W-1:0] OFF_P0_CTRL  = 5'h00;
    localparam logic [OFF_W-1:0] OFF_P0_SWEEP = 5'h01;
    localparam logic [OFF_W-1:0] OFF_P0_LO    = 5'h02;
    localparam logic [OFF_W-1:0] OFF_P0_HI    = 5'h03;
    localparam logic [OFF_W-1:0] OFF_P1_CTRL  = 5'h04;
    localparam logic [OFF_W-1:0] OFF_P1_SWEEP = 5'h05;
    localparam logic [OFF_W-1:0] OFF_P1_LO    = 5'h06;
    localparam logic [OFF_W-1:0] OFF_P1_HI    = 5'h07;
    localparam logic [OFF_W-1:0] OFF_TRI_LIN  = 5'h08;
    localparam logic [OFF_W-1:0] OFF_TRI_LO   = 5'h0A;
    localparam logic [OFF_W-1:0] OFF_TRI_HI   = 5'h0B;
    localparam logic [OFF_W-1:0] OFF_NS_CTRL  = 5'h0C;
    localparam logic [OFF_W-1:0] OFF_NS_PER   = 5'h0E;
    localparam logic [OFF_W-1:0] OFF_NS_LEN   = 5'h0F;
    localparam logic [OFF_W-1:0] OFF_DMC_CTRL = 5'h10;
    localparam logic [OFF_W-1:0] OFF_DMC_LVL  = 5'h11;
    localparam logic [OFF_W-1:0] OFF_DMC_ADDR = 5'h12;
    localparam logic [OFF_W-1:0] OFF_DMC_LEN  = 5'h13;
    localparam logic [OFF_W-1:0] OFF_STATUS   = 5'h15;
    localparam logic [OFF_W-1:0] OFF_FRAME    = 5'h17;

    // Flag bit positions of pulse and noise channels
    localparam int F_EN       = 0;
    localparam int F_LEN_EN   = 1;
    localparam int F_LOOP     = 2;
    localparam int F_ENV      = 3;
    localparam int F_START    = 4;
    localparam int F_SW_EN    = 5;
    localparam int F_SW_NEG   = 6;
    localparam int F_SW_RLD   = 7;
    localparam int F_NS_MODE  = 5;
    // Triangle flags
    localparam int T_EN       = 0;
    localparam int T_LEN_EN   = 1;
    localparam int T_RELOAD   = 2;
    // Sample playback flags
    localparam int D_EN       = 0;
    localparam int D_LOOP     = 1;
    localparam int D_IRQ      = 2;

    // Frame sequencer modes
    localparam logic [1:0] SEQ_STOP = 2'd0;
    localparam logic [1:0] SEQ_FOUR = 2'd1;
    localparam logic [1:0] SEQ_FIVE = 2'd2;

    typedef struct packed {
        logic [3:0] vol;
        logic [3:0] count;
        logic [3:0] param;
    } env_t;

    typedef struct packed {
        logic [3:0] period;
        logic [3:0] count;
        logic [2:0] shift;
    } sweep_t;

    typedef struct packed {
        logic             mode;
        logic [OFF_W-1:0] reg_offset;
        logic [7:0]       write_data;
        logic [7:0]       dmc_fetch_data;
    } in_word_t;

    typedef struct packed {
        logic               sample_valid;
        logic [LEVEL_W-1:0] sample_level;
        logic               frame_irq;
        logic [ADDR_W-1:0]  dmc_fetch_addr;
    } out_word_t;

    function automatic logic [7:0] len_lookup(input logic [4:0] idx);
        logic [7:0] r;
        case (idx)
            5'd0:  r = 8'd10;  5'd1:  r = 8'd254; 5'd2:  r = 8'd20;  5'd3:  r = 8'd2;
            5'd4:  r = 8'd40;  5'd5:  r = 8'd4;   5'd6:  r = 8'd80;  5'd7:  r = 8'd6;
            5'd8:  r = 8'd160; 5'd9:  r = 8'd8;   5'd10: r = 8'd60;  5'd11: r = 8'd10;
            5'd12: r = 8'd14;  5'd13: r = 8'd12;  5'd14: r = 8'd26;  5'd15: r = 8'd14;
            5'd16: r = 8'd12;  5'd17: r = 8'd16;  5'd18: r = 8'd24;  5'd19: r = 8'd18;
            5'd20: r = 8'd48;  5'd21: r = 8'd20;  5'd22: r = 8'd96;  5'd23: r = 8'd22;
            5'd24: r = 8'd192; 5'd25: r = 8'd24;  5'd26: r = 8'd72;  5'd27: r = 8'd26;
            5'd28: r = 8'd16;  5'd29: r = 8'd28;  5'd30: r = 8'd32;  default: r = 8'd30;
        endcase
        return r;
    endfunction

    // Duty waveforms, one row of eight steps per duty setting.
    function automatic logic duty_lookup(input logic [1:0] sel, input logic [2:0] step);
        logic [7:0] row;
        case (sel)
            2'd0:    row = 8'b0000_0010;
            2'd1:    row = 8'b0000_0110;
            2'd2:    row = 8'b0001_1110;
            default: row = 8'b1111_1001;
        endcase
        return row[step];
    endfunction

    // Triangle: falls 15..0, then rises 0..15.
    function automatic logic [3:0] tri_lookup(input logic [4:0] step);
        return step[4] ? step[3:0] : ~step[3:0];
    endfunction

    function automatic logic [11:0] noise_lookup(input logic [3:0] idx);
        logic [11:0] r;
        case (idx)
            4'd0:  r = 12'd4;    4'd1:  r = 12'd8;    4'd2:  r = 12'd16;   4'd3:  r = 12'd32;
            4'd4:  r = 12'd64;   4'd5:  r = 12'd96;   4'd6:  r = 12'd128;  4'd7:  r = 12'd160;
            4'd8:  r = 12'd202;  4'd9:  r = 12'd254;  4'd10: r = 12'd380;  4'd11: r = 12'd508;
            4'd12: r = 12'd762;  4'd13: r = 12'd1016; 4'd14: r = 12'd2034; default: r = 12'd4068;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] dmc_lookup(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0:  r = 8'd214; 4'd1:  r = 8'd190; 4'd2:  r = 8'd170; 4'd3:  r = 8'd160;
            4'd4:  r = 8'd143; 4'd5:  r = 8'd127; 4'd6:  r = 8'd113; 4'd7:  r = 8'd107;
            4'd8:  r = 8'd95;  4'd9:  r = 8'd80;  4'd10: r = 8'd71;  4'd11: r = 8'd64;
            4'd12: r = 8'd53;  4'd13: r = 8'd42;  4'd14: r = 8'd36;  default: r = 8'd27;
        endcase
        return r;
    endfunction

endpackage

[design/console_sound_generator_top.sv]
// Top level of the console sound generator: channel state, frame sequencer,
// phase accumulators, mixer tables and the output register. Uses csg_pkg.
//
// Each input word is either one CPU clock tick or one register write, and it
// yields exactly one output word. The block takes one word per clock cycle:
// all channel updates and the mix are done in one pass of logic between the
// channel state registers and the output register, so a word accepted at one
// edge has its result visible after that edge, and input is stalled only
// while a held result waits for out_ready.
module console_sound_generator_top #(
    parameter int MIX_FRACTION_BITS = csg_pkg::MIX_FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  csg_pkg::in_word_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output csg_pkg::out_word_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csg_pkg::PHASE_W-1:0]        cfg_data
);
    import csg_pkg::*;

    // Mixer tables, computed at elaboration.
    logic [LEVEL_W-1:0] pulse_lut [PULSE_N];
    logic [LEVEL_W-1:0] tnd_lut   [TND_N];

    for (genvar i = 0; i < PULSE_N; i++) begin : g_pulse_lut
        localparam longint unsigned NUM = (PULSE_COEF * i) << MIX_FRACTION_BITS;
        localparam longint unsigned DEN = 64'd100 * (PULSE_BASE + 64'd100 * i);
        localparam longint unsigned ENT = (i == 0) ? 64'd0 : (NUM + DEN / 2) / DEN;
        assign pulse_lut[i] = ENT[LEVEL_W-1:0];
    end

    for (genvar i = 0; i < TND_N; i++) begin : g_tnd_lut
        localparam longint unsigned NUM = (TND_COEF * i) << MIX_FRACTION_BITS;
        localparam longint unsigned DEN = 64'd100 * (TND_BASE + 64'd100 * i);
        localparam longint unsigned ENT = (i == 0) ? 64'd0 : (NUM + DEN / 2) / DEN;
        assign tnd_lut[i] = ENT[LEVEL_W-1:0];
    end

    // Configuration registers
    logic [PHASE_W-1:0] sample_step_reg, frame_step_reg, modulus_reg;

    // Channel state
    logic [15:0] pulse_period_reg [2], pulse_period_next [2];
    logic [15:0] pulse_timer_reg  [2], pulse_timer_next  [2];
    logic [2:0]  pulse_duty_step_reg [2], pulse_duty_step_next [2];
    logic [1:0]  pulse_duty_sel_reg  [2], pulse_duty_sel_next  [2];
    logic [7:0]  pulse_length_reg [2], pulse_length_next [2];
    logic [7:0]  pulse_flags_reg  [2], pulse_flags_next  [2];
    env_t        pulse_env_reg    [2], pulse_env_next    [2];
    sweep_t      pulse_sweep_reg  [2], pulse_sweep_next  [2];

    logic [10:0] tri_period_reg, tri_period_next;
    logic [10:0] tri_timer_reg, tri_timer_next;
    logic [4:0]  tri_step_reg, tri_step_next;
    logic [6:0]  tri_lin_reload_reg, tri_lin_reload_next;
    logic [6:0]  tri_lin_count_reg, tri_lin_count_next;
    logic [7:0]  tri_length_reg, tri_length_next;
    logic [2:0]  tri_flags_reg, tri_flags_next;

    logic [14:0] noise_lfsr_reg, noise_lfsr_next;
    logic [11:0] noise_timer_reg, noise_timer_next;
    logic [11:0] noise_period_reg, noise_period_next;
    logic [7:0]  noise_length_reg, noise_length_next;
    env_t        noise_env_reg, noise_env_next;
    logic [7:0]  noise_flags_reg, noise_flags_next;

    logic [7:0]  dmc_tperiod_reg, dmc_tperiod_next;
    logic [7:0]  dmc_tcount_reg, dmc_tcount_next;
    logic [6:0]  dmc_level_reg, dmc_level_next;
    logic [7:0]  dmc_bits_reg, dmc_bits_next;
    logic [3:0]  dmc_scount_reg, dmc_scount_next;
    logic [15:0] dmc_addr_reg, dmc_addr_next;
    logic [11:0] dmc_remaining_reg, dmc_remaining_next;
    logic [15:0] dmc_start_addr_reg, dmc_start_addr_next;
    logic [11:0] dmc_start_len_reg, dmc_start_len_next;
    logic [2:0]  dmc_flags_reg, dmc_flags_next;

    logic        parity_reg, parity_next;
    logic [1:0]  seq_mode_reg, seq_mode_next;
    logic [2:0]  seq_step_reg, seq_step_next;
    logic        seq_irq_en_reg, seq_irq_en_next;
    logic [PHASE_W-1:0] sample_phase_reg, sample_phase_next;
    logic [PHASE_W-1:0] frame_phase_reg, frame_phase_next;

    logic      out_valid_reg;
    out_word_t out_data_reg, out_data_next;

    logic accept;

    // Envelope divider and decay step.
    function automatic env_t env_tick(input env_t e, input logic start, input logic loop_en);
        env_t r;
        r = e;
        if (start) begin
            r.vol   = 4'd15;
            r.count = e.param;
        end else if (e.count != 4'd0) begin
            r.count = e.count - 4'd1;
        end else begin
            if (e.vol != 4'd0) begin
                r.vol = e.vol - 4'd1;
            end else if (loop_en) begin
                r.vol = 4'd15;
            end
            r.count = e.param;
        end
        return r;
    endfunction

    // Sweep target period; channel zero negates in ones' complement.
    function automatic logic [15:0] sweep_target(input logic [15:0] p, input logic [2:0] sh,
                                                 input logic neg, input logic ones);
        logic [15:0] d;
        d = p >> sh;
        return neg ? (p - d - {15'd0, ones}) : (p + d);
    endfunction

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // Next state and result for one word.
    always_comb
    begin
        logic        do_q;
        logic        do_h;
        logic        irq;
        logic        hit_s;
        logic        hit_f;
        logic [PHASE_W:0] sum;
        logic [7:0]  v;
        logic        ch;
        logic        fb;
        logic [3:0]  pv [2];
        logic [3:0]  tv;
        logic [3:0]  nv;
        logic [4:0]  psum;
        logic [7:0]  tidx;
        logic [LEVEL_W-1:0] lvl;

        pulse_period_next    = pulse_period_reg;
        pulse_timer_next     = pulse_timer_reg;
        pulse_duty_step_next = pulse_duty_step_reg;
        pulse_duty_sel_next  = pulse_duty_sel_reg;
        pulse_length_next    = pulse_length_reg;
        pulse_flags_next     = pulse_flags_reg;
        pulse_env_next       = pulse_env_reg;
        pulse_sweep_next     = pulse_sweep_reg;
        tri_period_next      = tri_period_reg;
        tri_timer_next       = tri_timer_reg;
        tri_step_next        = tri_step_reg;
        tri_lin_reload_next  = tri_lin_reload_reg;
        tri_lin_count_next   = tri_lin_count_reg;
        tri_length_next      = tri_length_reg;
        tri_flags_next       = tri_flags_reg;
        noise_lfsr_next      = noise_lfsr_reg;
        noise_timer_next     = noise_timer_reg;
        noise_period_next    = noise_period_reg;
        noise_length_next    = noise_length_reg;
        noise_env_next       = noise_env_reg;
        noise_flags_next     = noise_flags_reg;
        dmc_tperiod_next     = dmc_tperiod_reg;
        dmc_tcount_next      = dmc_tcount_reg;
        dmc_level_next       = dmc_level_reg;
        dmc_bits_next        = dmc_bits_reg;
        dmc_scount_next      = dmc_scount_reg;
        dmc_addr_next        = dmc_addr_reg;
        dmc_remaining_next   = dmc_remaining_reg;
        dmc_start_addr_next  = dmc_start_addr_reg;
        dmc_start_len_next   = dmc_start_len_reg;
        dmc_flags_next       = dmc_flags_reg;
        parity_next          = parity_reg;
        seq_mode_next        = seq_mode_reg;
        seq_step_next        = seq_step_reg;
        seq_irq_en_next      = seq_irq_en_reg;
        sample_phase_next    = sample_phase_reg;
        frame_phase_next     = frame_phase_reg;

        do_q  = 1'b0;
        do_h  = 1'b0;
        irq   = 1'b0;
        hit_s = 1'b0;
        hit_f = 1'b0;
        sum   = '0;
        fb    = 1'b0;
        v     = in_data.write_data;
        ch    = in_data.reg_offset[2];

        if (in_data.mode) begin
            // Register write
            unique case (in_data.reg_offset)
                OFF_P0_CTRL, OFF_P1_CTRL:
                begin
                    pulse_duty_sel_next[ch] = v[7:6];
                    pulse_flags_next[ch] = pulse_flags_reg[ch] & 8'hE1;
                    pulse_flags_next[ch][v[5] ? F_LOOP : F_LEN_EN] = 1'b1;
                    pulse_flags_next[ch][F_ENV]   = !v[4];
                    pulse_flags_next[ch][F_START] = 1'b1;
                    pulse_env_next[ch].param = v[3:0];
                end
                OFF_P0_SWEEP, OFF_P1_SWEEP:
                begin
                    pulse_flags_next[ch][F_SW_EN]  = v[7];
                    pulse_flags_next[ch][F_SW_NEG] = v[3];
                    pulse_flags_next[ch][F_SW_RLD] = 1'b1;
                    pulse_sweep_next[ch].period = {1'b0, v[6:4]} + 4'd1;
                    pulse_sweep_next[ch].shift  = v[2:0];
                end
                OFF_P0_LO, OFF_P1_LO:
                begin
                    pulse_period_next[ch][7:0] = v;
                end
                OFF_P0_HI, OFF_P1_HI:
                begin
                    pulse_length_next[ch] = len_lookup(v[7:3]);
                    pulse_period_next[ch] = {5'd0, v[2:0], pulse_period_reg[ch][7:0]};
                    pulse_flags_next[ch][F_START] = 1'b1;
                    pulse_duty_step_next[ch] = 3'd0;
                end
                OFF_TRI_LIN:
                begin
                    tri_flags_next[T_LEN_EN] = !v[7];
                    tri_lin_reload_next = v[6:0];
                end
                OFF_TRI_LO:
                begin
                    tri_period_next[7:0] = v;
                end
                OFF_TRI_HI:
                begin
                    tri_length_next = len_lookup(v[7:3]);
                    tri_period_next = {v[2:0], tri_period_reg[7:0]};
                    tri_timer_next  = {v[2:0], tri_period_reg[7:0]};
                    tri_flags_next[T_RELOAD] = 1'b1;
                end
                OFF_NS_CTRL:
                begin
                    noise_flags_next = noise_flags_reg & 8'h21;
                    noise_flags_next[v[5] ? F_LOOP : F_LEN_EN] = 1'b1;
                    noise_flags_next[F_ENV]   = !v[4];
                    noise_flags_next[F_START] = 1'b1;
                    noise_env_next.param = v[3:0];
                end
                OFF_NS_PER:
                begin
                    noise_flags_next[F_NS_MODE] = v[7];
                    noise_period_next = noise_lookup(v[3:0]);
                end
                OFF_NS_LEN:
                begin
                    noise_length_next = len_lookup(v[7:3]);
                    noise_flags_next[F_START] = 1'b1;
                end
                OFF_DMC_CTRL:
                begin
                    dmc_flags_next[D_IRQ]  = v[7];
                    dmc_flags_next[D_LOOP] = v[6];
                    dmc_tperiod_next = dmc_lookup(v[3:0]);
                end
                OFF_DMC_LVL:
                begin
                    dmc_level_next = v[6:0];
                end
                OFF_DMC_ADDR:
                begin
                    dmc_start_addr_next = {2'b11, v, 6'd0};
                end
                OFF_DMC_LEN:
                begin
                    dmc_start_len_next = {v, 4'b0001};
                end
                OFF_STATUS:
                begin
                    for (int c = 0; c < 2; c++) begin
                        pulse_flags_next[c][F_EN] = v[c];
                        if (!v[c]) begin
                            pulse_length_next[c] = 8'd0;
                        end
                    end
                    tri_flags_next[T_EN] = v[2];
                    if (!v[2]) begin
                        tri_length_next = 8'd0;
                    end
                    noise_flags_next[F_EN] = v[3];
                    if (!v[3]) begin
                        noise_length_next = 8'd0;
                    end
                    dmc_flags_next[D_EN] = v[4];
                    if (!v[4]) begin
                        dmc_remaining_next = 12'd0;
                    end else if (dmc_remaining_reg == 12'd0) begin
                        dmc_addr_next      = dmc_start_addr_reg;
                        dmc_remaining_next = dmc_start_len_reg;
                    end
                end
                OFF_FRAME:
                begin
                    seq_mode_next   = v[7] ? SEQ_FIVE : SEQ_FOUR;
                    seq_irq_en_next = !v[6];
                    do_q = v[7];
                    do_h = v[7];
                end
                default:
                begin
                end
            endcase
        end else begin
            // CPU clock tick; the APU-rate units run on every other tick.
            parity_next = !parity_reg;
            if (parity_reg) begin
                for (int c = 0; c < 2; c++) begin
                    if (pulse_timer_reg[c] == 16'd0) begin
                        pulse_timer_next[c]     = pulse_period_reg[c];
                        pulse_duty_step_next[c] = pulse_duty_step_reg[c] + 3'd1;
                    end else begin
                        pulse_timer_next[c] = pulse_timer_reg[c] - 16'd1;
                    end
                end

                if (noise_timer_reg == 12'd0) begin
                    fb = noise_lfsr_reg[0] ^
                         (noise_flags_reg[F_NS_MODE] ? noise_lfsr_reg[6] : noise_lfsr_reg[1]);
                    noise_timer_next = noise_period_reg;
                    noise_lfsr_next  = {fb, noise_lfsr_reg[14:1]};
                end else begin
                    noise_timer_next = noise_timer_reg - 12'd1;
                end

                // Sample playback: byte fetch, then output unit.
                if (dmc_flags_reg[D_EN]) begin
                    if (dmc_remaining_reg != 12'd0 && dmc_scount_reg == 4'd0) begin
                        dmc_bits_next   = in_data.dmc_fetch_data;
                        dmc_scount_next = 4'd8;
                        dmc_addr_next   = dmc_addr_reg + 16'd1;
                        if (dmc_addr_next == 16'd0) begin
                            dmc_addr_next = DMC_WRAP_ADDR;
                        end
                        dmc_remaining_next = dmc_remaining_reg - 12'd1;
                        if (dmc_remaining_next == 12'd0 && dmc_flags_reg[D_LOOP]) begin
                            dmc_addr_next      = dmc_start_addr_reg;
                            dmc_remaining_next = dmc_start_len_reg;
                        end
                    end
                    if (dmc_tcount_reg == 8'd0) begin
                        dmc_tcount_next = dmc_tperiod_reg;
                        if (dmc_scount_next != 4'd0) begin
                            if (dmc_bits_next[0]) begin
                                if (dmc_level_reg <= DMC_LEVEL_TOP) begin
                                    dmc_level_next = dmc_level_reg + 7'd2;
                                end
                            end else if (dmc_level_reg >= 7'd2) begin
                                dmc_level_next = dmc_level_reg - 7'd2;
                            end
                            dmc_bits_next   = {1'b0, dmc_bits_next[7:1]};
                            dmc_scount_next = dmc_scount_next - 4'd1;
                        end
                    end else begin
                        dmc_tcount_next = dmc_tcount_reg - 8'd1;
                    end
                end
            end

            // Triangle timer runs on every tick.
            if (tri_timer_reg == 11'd0) begin
                tri_timer_next = tri_period_reg;
                if (tri_length_reg != 8'd0 && tri_lin_count_reg != 7'd0) begin
                    tri_step_next = tri_step_reg + 5'd1;
                end
            end else begin
                tri_timer_next = tri_timer_reg - 11'd1;
            end

            // Frame strobe accumulator
            sum = {1'b0, frame_phase_reg} + {1'b0, frame_step_reg};
            hit_f = sum >= {1'b0, modulus_reg};
            if (hit_f) begin
                sum = sum - {1'b0, modulus_reg};
            end
            frame_phase_next = sum[PHASE_W-1:0];

            // Sample strobe accumulator
            sum = {1'b0, sample_phase_reg} + {1'b0, sample_step_reg};
            hit_s = sum >= {1'b0, modulus_reg};
            if (hit_s) begin
                sum = sum - {1'b0, modulus_reg};
            end
            sample_phase_next = sum[PHASE_W-1:0];

            // Frame sequencer step
            if (hit_f) begin
                if (seq_mode_reg == SEQ_FOUR) begin
                    seq_step_next = {1'b0, seq_step_reg[1:0] + 2'd1};
                    do_q = 1'b1;
                    do_h = seq_step_next[0];
                    irq  = (seq_step_next == 3'd3) && seq_irq_en_reg;
                end else if (seq_mode_reg == SEQ_FIVE) begin
                    seq_step_next = (seq_step_reg >= 3'd4) ? 3'd0 : seq_step_reg + 3'd1;
                    do_q = seq_step_next != 3'd4;
                    do_h = (seq_step_next == 3'd0) || (seq_step_next == 3'd2);
                end
            end
        end

        // Quarter-frame clock: envelopes and triangle linear counter.
        if (do_q) begin
            for (int c = 0; c < 2; c++) begin
                pulse_env_next[c] = env_tick(pulse_env_next[c], pulse_flags_next[c][F_START],
                                             pulse_flags_next[c][F_LOOP]);
                pulse_flags_next[c][F_START] = 1'b0;
            end
            if (tri_flags_next[T_RELOAD]) begin
                tri_lin_count_next = tri_lin_reload_next;
            end else if (tri_lin_count_next != 7'd0) begin
                tri_lin_count_next = tri_lin_count_next - 7'd1;
            end
            if (tri_flags_next[T_LEN_EN]) begin
                tri_flags_next[T_RELOAD] = 1'b0;
            end
            noise_env_next = env_tick(noise_env_next, noise_flags_next[F_START],
                                      noise_flags_next[F_LOOP]);
            noise_flags_next[F_START] = 1'b0;
        end

        // Half-frame clock: sweeps and length counters.
        if (do_h) begin
            for (int c = 0; c < 2; c++) begin
                if (pulse_flags_next[c][F_SW_RLD]) begin
                    if (pulse_flags_next[c][F_SW_EN] && pulse_sweep_next[c].count == 4'd0) begin
                        pulse_period_next[c] = sweep_target(pulse_period_next[c],
                            pulse_sweep_next[c].shift, pulse_flags_next[c][F_SW_NEG], c == 0);
                    end
                    pulse_sweep_next[c].count = pulse_sweep_next[c].period;
                    pulse_flags_next[c][F_SW_RLD] = 1'b0;
                end else if (pulse_sweep_next[c].count != 4'd0) begin
                    pulse_sweep_next[c].count = pulse_sweep_next[c].count - 4'd1;
                end else begin
                    if (pulse_flags_next[c][F_SW_EN]) begin
                        pulse_period_next[c] = sweep_target(pulse_period_next[c],
                            pulse_sweep_next[c].shift, pulse_flags_next[c][F_SW_NEG], c == 0);
                    end
                    pulse_sweep_next[c].count = pulse_sweep_next[c].period;
                end
                if (pulse_flags_next[c][F_LEN_EN] && pulse_length_next[c] != 8'd0) begin
                    pulse_length_next[c] = pulse_length_next[c] - 8'd1;
                end
            end
            if (tri_flags_next[T_LEN_EN] && tri_length_next != 8'd0) begin
                tri_length_next = tri_length_next - 8'd1;
            end
            if (noise_flags_next[F_LEN_EN] && noise_length_next != 8'd0) begin
                noise_length_next = noise_length_next - 8'd1;
            end
        end

        // Channel outputs and mix from the updated state.
        for (int c = 0; c < 2; c++) begin
            pv[c] = 4'd0;
            if (pulse_flags_next[c][F_EN] && pulse_length_next[c] != 8'd0 &&
                duty_lookup(pulse_duty_sel_next[c], pulse_duty_step_next[c]) &&
                pulse_period_next[c] >= 16'd8 &&
                pulse_period_next[c] <= {5'd0, PERIOD_LIMIT}) begin
                pv[c] = pulse_flags_next[c][F_ENV] ? pulse_env_next[c].vol
                                                   : pulse_env_next[c].param;
            end
        end
        tv = 4'd0;
        if (tri_flags_next[T_EN] && tri_length_next != 8'd0 && tri_lin_count_next != 7'd0) begin
            tv = tri_lookup(tri_step_next);
        end
        nv = 4'd0;
        if (noise_flags_next[F_EN] && noise_length_next != 8'd0 && !noise_lfsr_next[0]) begin
            nv = noise_flags_next[F_ENV] ? noise_env_next.vol : noise_env_next.param;
        end
        psum = {1'b0, pv[0]} + {1'b0, pv[1]};
        tidx = ({4'd0, tv} << 1) + {4'd0, tv} + ({4'd0, nv} << 1) + {1'b0, dmc_level_next};
        lvl  = pulse_lut[psum] + tnd_lut[tidx];

        out_data_next.sample_valid   = hit_s;
        out_data_next.sample_level   = hit_s ? lvl : '0;
        out_data_next.frame_irq      = irq;
        out_data_next.dmc_fetch_addr = dmc_addr_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sample_step_reg <= SAMPLE_STEP_RST;
            frame_step_reg  <= FRAME_STEP_RST;
            modulus_reg     <= MODULUS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SAMPLE_STEP: sample_step_reg <= cfg_data;
                CFG_FRAME_STEP:  frame_step_reg  <= cfg_data;
                CFG_MODULUS:     modulus_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Channel state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int c = 0; c < 2; c++) begin
                pulse_period_reg[c]    <= '0;
                pulse_timer_reg[c]     <= '0;
                pulse_duty_step_reg[c] <= '0;
                pulse_duty_sel_reg[c]  <= '0;
                pulse_length_reg[c]    <= '0;
                pulse_flags_reg[c]     <= '0;
                pulse_env_reg[c]       <= '0;
                pulse_sweep_reg[c]     <= '0;
            end
            tri_period_reg     <= '0;
            tri_timer_reg      <= '0;
            tri_step_reg       <= '0;
            tri_lin_reload_reg <= '0;
            tri_lin_count_reg  <= '0;
            tri_length_reg     <= '0;
            tri_flags_reg      <= '0;
            noise_lfsr_reg     <= 15'd1;
            noise_timer_reg    <= '0;
            noise_period_reg   <= '0;
            noise_length_reg   <= '0;
            noise_env_reg      <= '0;
            noise_flags_reg    <= '0;
            dmc_tperiod_reg    <= '0;
            dmc_tcount_reg     <= '0;
            dmc_level_reg      <= '0;
            dmc_bits_reg       <= '0;
            dmc_scount_reg     <= '0;
            dmc_addr_reg       <= '0;
            dmc_remaining_reg  <= '0;
            dmc_start_addr_reg <= '0;
            dmc_start_len_reg  <= '0;
            dmc_flags_reg      <= '0;
            parity_reg         <= 1'b0;
            seq_mode_reg       <= SEQ_STOP;
            seq_step_reg       <= '0;
            seq_irq_en_reg     <= 1'b0;
            sample_phase_reg   <= '0;
            frame_phase_reg    <= '0;
        end else if (accept) begin
            pulse_period_reg    <= pulse_period_next;
            pulse_timer_reg     <= pulse_timer_next;
            pulse_duty_step_reg <= pulse_duty_step_next;
            pulse_duty_sel_reg  <= pulse_duty_sel_next;
            pulse_length_reg    <= pulse_length_next;
            pulse_flags_reg     <= pulse_flags_next;
            pulse_env_reg       <= pulse_env_next;
            pulse_sweep_reg     <= pulse_sweep_next;
            tri_period_reg      <= tri_period_next;
            tri_timer_reg       <= tri_timer_next;
            tri_step_reg        <= tri_step_next;
            tri_lin_reload_reg  <= tri_lin_reload_next;
            tri_lin_count_reg   <= tri_lin_count_next;
            tri_length_reg      <= tri_length_next;
            tri_flags_reg       <= tri_flags_next;
            noise_lfsr_reg      <= noise_lfsr_next;
            noise_timer_reg     <= noise_timer_next;
            noise_period_reg    <= noise_period_next;
            noise_length_reg    <= noise_length_next;
            noise_env_reg       <= noise_env_next;
            noise_flags_reg     <= noise_flags_next;
            dmc_tperiod_reg     <= dmc_tperiod_next;
            dmc_tcount_reg      <= dmc_tcount_next;
            dmc_level_reg       <= dmc_level_next;
            dmc_bits_reg        <= dmc_bits_next;
            dmc_scount_reg      <= dmc_scount_next;
            dmc_addr_reg        <= dmc_addr_next;
            dmc_remaining_reg   <= dmc_remaining_next;
            dmc_start_addr_reg  <= dmc_start_addr_next;
            dmc_start_len_reg   <= dmc_start_len_next;
            dmc_flags_reg       <= dmc_flags_next;
            parity_reg          <= parity_next;
            seq_mode_reg        <= seq_mode_next;
            seq_step_reg        <= seq_step_next;
            seq_irq_en_reg      <= seq_irq_en_next;
            sample_phase_reg    <= sample_phase_next;
            frame_phase_reg     <= frame_phase_next;
        end
    end

    // Output register: loads a result word on every accepted input word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
